[rtl/core/paired_page_tlb_memory_top_defines.svh]
// assertion macros shared by the checker
`ifndef PAIRED_PAGE_TLB_MEMORY_TOP_DEFINES_SVH
`define PAIRED_PAGE_TLB_MEMORY_TOP_DEFINES_SVH

// clocked assertion with asynchronous reset disable
`define PPTM_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define PPTM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/pptm_pkg.sv]
`default_nettype none
package pptm_pkg;

	// operation codes
	localparam logic [2:0] OP_RD_WORD = 3'd0;
	localparam logic [2:0] OP_WR_WORD = 3'd1;
	localparam logic [2:0] OP_RD_BYTE = 3'd2;
	localparam logic [2:0] OP_WR_BYTE = 3'd3;
	localparam logic [2:0] OP_CHECK   = 3'd4;
	localparam logic [2:0] OP_ADD_MAP = 3'd5;

	// status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	localparam logic [31:0] BYPASS_MASK = 32'h1FFF_FFFF;
	localparam logic [31:0] PAGE_MASK   = 32'h0000_0FFF;
	localparam logic [31:0] ALL_ONES    = 32'hFFFF_FFFF;
	localparam int          TAG_W       = 19;
	localparam int          FRAME_W     = 20;
	localparam int          QDEPTH      = 2;

	typedef struct packed {
		logic [2:0]  operation;
		logic [31:0] address;
		logic [31:0] write_data;
	} in_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic [1:0]  status;
	} out_t;

	// work classes for the back end
	typedef enum logic [2:0] {
		K_DONE,
		K_RD_WORD,
		K_WR_WORD,
		K_RD_BYTE,
		K_WR_BYTE
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [29:0] word;
		logic [1:0]  lane;
		logic [31:0] data;
		logic [1:0]  status;
	} cmd_t;

	// replace one byte lane of a word
	function automatic logic [31:0] merge_byte(input logic [31:0] w, input logic [1:0] lane,
			input logic [7:0] b);
		logic [31:0] mask;
		logic [31:0] ins;
		mask = 32'h0000_00FF << {lane, 3'b000};
		ins  = {24'd0, b} << {lane, 3'b000};
		return (w & ~mask) | ins;
	endfunction

endpackage
`default_nettype wire

[rtl/core/paired_page_tlb_memory_top.sv]
// Word memory behind a paired-page translation buffer.
// Input channel: present item (operation, address, write_data) with start; the
// transaction is taken at a clock edge where start is high and busy is low.
// Output channel: done pulses for one cycle with result (read_data, status);
// the receiver takes it in that cycle and cannot stall it.
// The front end translates and, for add translation, updates the buffer in the
// accept cycle, then queues a command (two deep) for the back end.
// Non-memory operations and word writes complete when the back end takes their
// command from the queue; reads and byte writes pass through a second state
// (synchronous RAM read, then result or merged write-back).
// The back end takes a new command only when idle, so reads and byte writes
// hold it for that extra state before the next command is taken.
// busy is high while the command queue is full.
// After reset the back end clears every memory word to all ones, one word a
// cycle; busy stays high during that pass.
// The translation buffer is empty after reset.
`default_nettype none
module paired_page_tlb_memory_top #(
	parameter int MEM_WORDS   = 65536,
	parameter int TLB_ENTRIES = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire pptm_pkg::in_t item,
	output logic               done,
	output pptm_pkg::out_t     result
);
	pptm_pkg::cmd_t cmd;
	pptm_pkg::cmd_t head;
	logic           accept;
	logic           pop;
	logic           full;
	logic           empty;
	logic           clearing;

	// input handshake
	assign accept = start && !busy;
	assign busy   = clearing || full;

	pptm_front #(
		.MEM_WORDS  (MEM_WORDS),
		.TLB_ENTRIES(TLB_ENTRIES)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.accept(accept),
		.item  (item),
		.cmd   (cmd)
	);

	pptm_cmdq u_cmdq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (accept),
		.din   (cmd),
		.pop   (pop),
		.dout  (head),
		.full  (full),
		.empty (empty)
	);

	pptm_back #(
		.MEM_WORDS(MEM_WORDS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.empty   (empty),
		.pop     (pop),
		.clearing(clearing),
		.done    (done),
		.result  (result)
	);
endmodule
`default_nettype wire

[rtl/core/pptm_ram.sv]
`default_nettype none
module pptm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

[rtl/core/pptm_front.sv]
`default_nettype none
module pptm_front #(
	parameter int MEM_WORDS   = 65536,
	parameter int TLB_ENTRIES = 8
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           accept,
	input  wire pptm_pkg::in_t  item,
	output pptm_pkg::cmd_t      cmd
);
	localparam int IW = $clog2(TLB_ENTRIES);

	logic [pptm_pkg::TAG_W-1:0]   tag_q   [TLB_ENTRIES];
	logic [pptm_pkg::FRAME_W-1:0] efr_q   [TLB_ENTRIES];
	logic [pptm_pkg::FRAME_W-1:0] ofr_q   [TLB_ENTRIES];
	logic [TLB_ENTRIES-1:0]       evld_q;
	logic [TLB_ENTRIES-1:0]       ovld_q;

	logic [pptm_pkg::TAG_W-1:0] tag;
	logic                       odd;
	logic                       bypass;
	logic                       hit_any;
	logic [IW-1:0]              hit_idx;
	logic                       free_any;
	logic [IW-1:0]              free_idx;
	logic                       xlat_ok;
	logic [31:0]                pa;
	logic                       in_range;
	logic                       mem_ok;
	logic [pptm_pkg::FRAME_W-1:0] frame;

	assign tag    = item.address[31:13];
	assign odd    = item.address[12];
	assign bypass = (item.address[31:29] == 3'd4) || (item.address[31:29] == 3'd5);

	// first matching tag and first empty entry
	always_comb begin
		hit_any  = 1'b0;
		hit_idx  = '0;
		free_any = 1'b0;
		free_idx = '0;
		for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
			if (tag_q[i] == tag) begin
				hit_any = 1'b1;
				hit_idx = IW'(i);
			end
			if (!evld_q[i] && !ovld_q[i]) begin
				free_any = 1'b1;
				free_idx = IW'(i);
			end
		end
	end

	// translation and range check
	always_comb begin
		frame = odd ? ofr_q[hit_idx] : efr_q[hit_idx];
		if (bypass) begin
			xlat_ok = 1'b1;
			pa      = item.address & pptm_pkg::BYPASS_MASK;
		end else begin
			xlat_ok = hit_any && (odd ? ovld_q[hit_idx] : evld_q[hit_idx]);
			pa      = {frame, 12'd0} | (item.address & pptm_pkg::PAGE_MASK);
		end
		in_range = {1'b0, pa[31:2]} < 31'(MEM_WORDS);
		mem_ok   = xlat_ok && in_range;
	end

	// classify the operation
	always_comb begin
		cmd.kind   = pptm_pkg::K_DONE;
		cmd.word   = pa[31:2];
		cmd.lane   = item.address[1:0];
		cmd.data   = item.write_data;
		cmd.status = pptm_pkg::ST_OK;
		unique case (item.operation)
			pptm_pkg::OP_RD_WORD: begin
				cmd.kind   = mem_ok ? pptm_pkg::K_RD_WORD : pptm_pkg::K_DONE;
				cmd.status = mem_ok ? pptm_pkg::ST_OK : pptm_pkg::ST_MISS;
			end
			pptm_pkg::OP_WR_WORD: begin
				cmd.kind   = mem_ok ? pptm_pkg::K_WR_WORD : pptm_pkg::K_DONE;
				cmd.status = mem_ok ? pptm_pkg::ST_OK : pptm_pkg::ST_MISS;
			end
			pptm_pkg::OP_RD_BYTE: begin
				cmd.kind   = mem_ok ? pptm_pkg::K_RD_BYTE : pptm_pkg::K_DONE;
				cmd.status = mem_ok ? pptm_pkg::ST_OK : pptm_pkg::ST_MISS;
			end
			pptm_pkg::OP_WR_BYTE: begin
				cmd.kind   = mem_ok ? pptm_pkg::K_WR_BYTE : pptm_pkg::K_DONE;
				cmd.status = mem_ok ? pptm_pkg::ST_OK : pptm_pkg::ST_MISS;
			end
			pptm_pkg::OP_CHECK: begin
				cmd.status = (mem_ok && pa[1:0] == 2'b00) ? pptm_pkg::ST_OK
					: pptm_pkg::ST_MISS;
			end
			pptm_pkg::OP_ADD_MAP: begin
				cmd.status = (bypass || hit_any || free_any) ? pptm_pkg::ST_OK
					: pptm_pkg::ST_FULL;
			end
			default: begin
				cmd.status = pptm_pkg::ST_OK;
			end
		endcase
	end

	// translation buffer update on add
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TLB_ENTRIES; i++) begin
				tag_q[i] <= '0;
				efr_q[i] <= '0;
				ofr_q[i] <= '0;
			end
			evld_q <= '0;
			ovld_q <= '0;
		end else if (accept && item.operation == pptm_pkg::OP_ADD_MAP && !bypass) begin
			priority if (hit_any) begin
				if (odd) begin
					ovld_q[hit_idx] <= 1'b1;
					ofr_q[hit_idx]  <= item.write_data[31:12];
				end else begin
					evld_q[hit_idx] <= 1'b1;
					efr_q[hit_idx]  <= item.write_data[31:12];
				end
			end else if (free_any) begin
				tag_q[free_idx] <= tag;
				if (odd) begin
					ovld_q[free_idx] <= 1'b1;
					ofr_q[free_idx]  <= item.write_data[31:12];
				end else begin
					evld_q[free_idx] <= 1'b1;
					efr_q[free_idx]  <= item.write_data[31:12];
				end
			end
		end
	end
endmodule
`default_nettype wire

[rtl/core/pptm_cmdq.sv]
`default_nettype none
module pptm_cmdq (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire pptm_pkg::cmd_t din,
	input  wire logic           pop,
	output pptm_pkg::cmd_t      dout,
	output logic                full,
	output logic                empty
);
	pptm_pkg::cmd_t slot_q [pptm_pkg::QDEPTH];
	logic           wptr_q;
	logic           rptr_q;
	logic [1:0]     cnt_q;

	assign dout  = slot_q[rptr_q];
	assign full  = cnt_q == 2'(pptm_pkg::QDEPTH);
	assign empty = cnt_q == 2'd0;

	// payload slots
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= din;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule
`default_nettype wire

[rtl/core/pptm_back.sv]
`default_nettype none
module pptm_back #(
	parameter int MEM_WORDS = 65536
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire pptm_pkg::cmd_t head,
	input  wire logic           empty,
	output logic                pop,
	output logic                clearing,
	output logic                done,
	output pptm_pkg::out_t      result
);
	localparam int AW = $clog2(MEM_WORDS);

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_RMW
	} state_t;

	state_t         state_q;
	logic [AW-1:0]  clr_q;
	pptm_pkg::cmd_t cur_q;
	logic           done_q;
	pptm_pkg::out_t res_q;

	logic          we;
	logic [AW-1:0] waddr;
	logic [31:0]   wdata;
	logic [AW-1:0] raddr;
	logic [31:0]   rdata;

	assign pop      = (state_q == S_IDLE) && !empty;
	assign clearing = state_q == S_CLEAR;
	assign done     = done_q;
	assign result   = res_q;

	// memory port control
	always_comb begin
		we    = 1'b0;
		waddr = head.word[AW-1:0];
		wdata = head.data;
		raddr = head.word[AW-1:0];
		unique case (state_q)
			S_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = pptm_pkg::ALL_ONES;
			end
			S_IDLE: begin
				we = pop && head.kind == pptm_pkg::K_WR_WORD;
			end
			S_RMW: begin
				we    = 1'b1;
				waddr = cur_q.word[AW-1:0];
				wdata = pptm_pkg::merge_byte(rdata, cur_q.lane, cur_q.data[7:0]);
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	pptm_ram #(
		.WIDTH(32),
		.DEPTH(MEM_WORDS)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(MEM_WORDS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (pop) begin
						cur_q <= head;
						unique case (head.kind)
							pptm_pkg::K_RD_WORD, pptm_pkg::K_RD_BYTE: begin
								state_q <= S_READ;
							end
							pptm_pkg::K_WR_BYTE: begin
								state_q <= S_RMW;
							end
							default: begin
								done_q           <= 1'b1;
								res_q.read_data <= 32'd0;
								res_q.status    <= head.status;
							end
						endcase
					end
				end
				S_READ: begin
					done_q       <= 1'b1;
					res_q.status <= cur_q.status;
					if (cur_q.kind == pptm_pkg::K_RD_BYTE) begin
						res_q.read_data <= 32'(8'(rdata >> {cur_q.lane, 3'b000}));
					end else begin
						res_q.read_data <= rdata;
					end
					state_q <= S_IDLE;
				end
				S_RMW: begin
					done_q           <= 1'b1;
					res_q.read_data <= 32'd0;
					res_q.status    <= cur_q.status;
					state_q          <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

[rtl/core/pptm_checker.sv]
`default_nettype none
`include "paired_page_tlb_memory_top_defines.svh"
module pptm_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           start,
	input wire logic           busy,
	input wire pptm_pkg::in_t  item,
	input wire logic           done,
	input wire pptm_pkg::out_t result
);
	// no status code beyond buffer full
	`PPTM_ASSERT(a_status_code, clk, arst_n, done |-> result.status != 2'd3, "bad status code")

	// a fault returns zero data
	`PPTM_ASSERT(a_miss_zero, clk, arst_n, (done && result.status == pptm_pkg::ST_MISS) |-> result.read_data == 32'd0, "fault with nonzero data")

	// buffer full returns zero data
	`PPTM_ASSERT(a_full_zero, clk, arst_n, (done && result.status == pptm_pkg::ST_FULL) |-> result.read_data == 32'd0, "full with nonzero data")

	// an accepted transaction carries a known operation
	`PPTM_ASSERT(a_item_known, clk, arst_n, (start && !busy) |-> !$isunknown(item.operation), "unknown operation accepted")

	// no result in the cycle after reset releases
	`PPTM_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |=> !done, "result during reset")
endmodule

bind paired_page_tlb_memory_top pptm_checker u_pptm_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.item  (item),
	.done  (done),
	.result(result)
);
`default_nettype wire

[sim/paired_page_tlb_memory_top_test.sv]
`default_nettype none
module paired_page_tlb_memory_top_test;
	import pptm_pkg::*;

	localparam int MEM_WORDS     = 65536;
	localparam int TLB_ENTRIES   = 8;
	localparam int STALL_LIMIT   = 200000;
	localparam logic [2:0] OP_SPARE_6 = 3'd6;
	localparam logic [2:0] OP_SPARE_7 = 3'd7;

	// expected results for the translated memory
	class tlb_memory_scoreboard;
		logic [18:0] tag_q [TLB_ENTRIES];
		logic [19:0] even_frame [TLB_ENTRIES];
		logic [19:0] odd_frame [TLB_ENTRIES];
		bit          even_ok [TLB_ENTRIES];
		bit          odd_ok [TLB_ENTRIES];
		logic [31:0] word_store [MEM_WORDS];
		out_t        pending_results [$];
		int          errors;

		function new();
			for (int i = 0; i < TLB_ENTRIES; i++) begin
				tag_q[i] = '0;
				even_frame[i] = '0;
				odd_frame[i] = '0;
				even_ok[i] = 0;
				odd_ok[i] = 0;
			end
			foreach (word_store[i]) word_store[i] = ALL_ONES;
			errors = 0;
		endfunction

		// virtual to physical, first matching tag decides
		function bit map_address(input logic [31:0] va, output logic [31:0] pa);
			pa = '0;
			if (va[31:29] == 3'd4 || va[31:29] == 3'd5) begin
				pa = va & BYPASS_MASK;
				return 1;
			end
			for (int i = 0; i < TLB_ENTRIES; i++) begin
				if (tag_q[i] == va[31:13]) begin
					if (!va[12] && even_ok[i]) begin
						pa = {even_frame[i], va[11:0]};
						return 1;
					end
					if (va[12] && odd_ok[i]) begin
						pa = {odd_frame[i], va[11:0]};
						return 1;
					end
					return 0;
				end
			end
			return 0;
		endfunction

		function void set_page(int i, logic odd, logic [19:0] frame);
			if (odd) begin
				odd_ok[i] = 1;
				odd_frame[i] = frame;
			end else begin
				even_ok[i] = 1;
				even_frame[i] = frame;
			end
		endfunction

		function logic [1:0] add_mapping(logic [31:0] va, logic [31:0] pa);
			if (va[31:29] == 3'd4 || va[31:29] == 3'd5) return ST_OK;
			for (int i = 0; i < TLB_ENTRIES; i++)
				if (tag_q[i] == va[31:13]) begin
					set_page(i, va[12], pa[31:12]);
					return ST_OK;
				end
			for (int i = 0; i < TLB_ENTRIES; i++)
				if (!even_ok[i] && !odd_ok[i]) begin
					tag_q[i] = va[31:13];
					set_page(i, va[12], pa[31:12]);
					return ST_OK;
				end
			return ST_FULL;
		endfunction

		// accepted transaction: update state and queue its result
		function void note_request(in_t req);
			out_t        r;
			logic [31:0] pa;
			logic [4:0]  sh;
			bit          hit;
			int          w;
			r = '0;
			hit = map_address(req.address, pa);
			hit = hit && (pa[31:2] < MEM_WORDS);
			w = pa[31:2];
			sh = {req.address[1:0], 3'b000};
			case (req.operation)
				OP_RD_WORD: if (hit) r.read_data = word_store[w]; else r.status = ST_MISS;
				OP_WR_WORD: if (hit) word_store[w] = req.write_data; else r.status = ST_MISS;
				OP_RD_BYTE: begin
					if (hit) r.read_data = (word_store[w] >> sh) & 32'hFF;
					else r.status = ST_MISS;
				end
				OP_WR_BYTE: begin
					if (hit) word_store[w] = (word_store[w] & ~(32'hFF << sh))
						| ({24'd0, req.write_data[7:0]} << sh);
					else r.status = ST_MISS;
				end
				OP_CHECK: if (!hit || pa[1:0] != 2'b00) r.status = ST_MISS;
				OP_ADD_MAP: r.status = add_mapping(req.address, req.write_data);
				default: ;
			endcase
			pending_results.push_back(r);
		endfunction

		function void check_result(out_t got);
			out_t exp_r;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result read_data=%h status=%0d", $time,
					got.read_data, got.status);
				errors++;
				return;
			end
			exp_r = pending_results.pop_front();
			if (got.read_data !== exp_r.read_data) begin
				$display("%0t: read_data expected %h actual %h", $time,
					exp_r.read_data, got.read_data);
				errors++;
			end
			if (got.status !== exp_r.status) begin
				$display("%0t: status expected %0d actual %0d", $time,
					exp_r.status, got.status);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	logic done;
	in_t  item = '0;
	out_t result;
	int   idle_pct = 0;
	int   quiet_cycles = 0;
	logic [18:0] tag_pool [12];
	tlb_memory_scoreboard sb = new();

	paired_page_tlb_memory_top #(
		.MEM_WORDS(MEM_WORDS),
		.TLB_ENTRIES(TLB_ENTRIES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.done(done),
		.result(result)
	);

	always #2 clk = ~clk;

	// result check and stall watchdog
	always @(posedge clk) begin
		if (arst_n && done) sb.check_result(result);
		if ((start && !busy) || done) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// one transaction, with optional sender gap first
	task automatic send(logic [2:0] op, logic [31:0] addr, logic [31:0] wdata);
		in_t req;
		req.operation = op;
		req.address = addr;
		req.write_data = wdata;
		if ($urandom_range(99) < idle_pct) begin
			start <= 0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		start <= 1;
		item <= req;
		do @(posedge clk); while (busy);
		sb.note_request(req);
		@(negedge clk);
	endtask

	function automatic logic [31:0] pick_address();
		logic [31:0] a;
		a = $urandom;
		case ($urandom_range(9))
			0, 1: begin
				a[31:29] = 3'($urandom_range(4, 5));
				if ($urandom_range(7) != 0) a[28:18] = '0;
			end
			2, 3, 4, 5, 6: a[31:13] = tag_pool[$urandom_range(11)];
			default: ;
		endcase
		return a;
	endfunction

	function automatic logic [31:0] pick_frame();
		logic [31:0] pa;
		pa = $urandom;
		if ($urandom_range(7) != 0) pa[31:12] = 20'($urandom_range(0, 70));
		return pa;
	endfunction

	task automatic random_item();
		int sel;
		sel = $urandom_range(99);
		if (sel < 10) send(OP_ADD_MAP, pick_address(), pick_frame());
		else if (sel < 13) send(3'($urandom_range(6, 7)), $urandom, $urandom);
		else send(3'($urandom_range(0, 4)), pick_address(), $urandom);
	endtask

	initial begin
		foreach (tag_pool[i]) tag_pool[i] = 19'($urandom);
		tag_pool[0] = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;

		// directed: bypass access, lanes, faults, mapping, spare codes
		send(OP_RD_WORD, 32'h8000_0000, 32'h0);
		send(OP_WR_WORD, 32'hA000_0004, 32'h1234_5678);
		send(OP_RD_WORD, 32'h8000_0007, 32'h0);
		send(OP_RD_BYTE, 32'h8000_0005, 32'h0);
		send(OP_WR_BYTE, 32'h8000_0006, 32'hFFFF_FFAB);
		send(OP_RD_WORD, 32'h8000_0004, 32'h0);
		send(OP_WR_BYTE, 32'h8000_0000, 32'h0000_0000);
		send(OP_RD_BYTE, 32'h8000_0000, 32'h0);
		send(OP_CHECK, 32'h8000_0002, 32'h0);
		send(OP_CHECK, 32'h9FFF_FFFC, 32'h0);
		send(OP_RD_WORD, 32'hBFFF_FFFC, 32'h0);
		send(OP_WR_WORD, 32'h0000_1000, 32'hDEAD_BEEF);
		send(OP_ADD_MAP, 32'h0040_1000, 32'h0000_3FFF);
		send(OP_WR_WORD, 32'h0040_1FFC, 32'hCAFE_F00D);
		send(OP_RD_WORD, 32'h8000_3FFC, 32'h0);
		send(OP_RD_WORD, 32'h0040_0000, 32'h0);
		send(OP_ADD_MAP, 32'h0040_0000, 32'hFFFF_F000);
		send(OP_CHECK, 32'h0040_0000, 32'h0);
		send(OP_ADD_MAP, 32'h8000_0000, 32'h0000_1000);
		send(OP_ADD_MAP, 32'hFFFF_F000, 32'h0001_0000);
		send(OP_RD_BYTE, 32'hFFFF_FFFF, 32'h0);
		send(OP_SPARE_6, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send(OP_SPARE_7, 32'h8000_0000, 32'h0);

		// random phases with different sender idling
		for (int p = 0; p < 5; p++) begin
			idle_pct = p == 1 ? 70 : (p == 3 ? 28 : 0);
			repeat (350) random_item();
			if (p == 1) begin
				start <= 0;
				while (sb.pending_results.size() != 0) @(negedge clk);
			end
		end
		start <= 0;

		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.errors == 0) $display("TB_OK");
		else $display("TB_ERROR");
		$finish;
	end
endmodule
`default_nettype wire
